@@ rtl/core/bracket_quote_comment_checker_macros.svh @@
// Assertion macros for the bracket, quote and comment checker.
// Depends on nothing; included by the modules that check their own logic.
`ifndef BRACKET_QUOTE_COMMENT_CHECKER_MACROS_SVH
`define BRACKET_QUOTE_COMMENT_CHECKER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BQCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BQCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bqcc_pkg.sv @@
// Package for the bracket, quote and comment checker: word types,
// significant-byte and stack-entry codes, and the byte classifier. No dependencies.
package bqcc_pkg;

    localparam int BQCC_STACK_DEPTH = 64;
    localparam int DEPTH_W          = 7;

    typedef logic [3:0] t_sig;
    typedef logic [2:0] t_ent;

    localparam t_sig SIG_NONE  = 4'd0;
    localparam t_sig SIG_LPAR  = 4'd1;
    localparam t_sig SIG_RPAR  = 4'd2;
    localparam t_sig SIG_LBRC  = 4'd3;
    localparam t_sig SIG_RBRC  = 4'd4;
    localparam t_sig SIG_LBRK  = 4'd5;
    localparam t_sig SIG_RBRK  = 4'd6;
    localparam t_sig SIG_SQ    = 4'd7;
    localparam t_sig SIG_DQ    = 4'd8;
    localparam t_sig SIG_BSL   = 4'd9;
    localparam t_sig SIG_SLASH = 4'd10;
    localparam t_sig SIG_STAR  = 4'd11;

    localparam t_ent ENT_NONE    = 3'd0;
    localparam t_ent ENT_PAREN   = 3'd1;
    localparam t_ent ENT_BRACE   = 3'd2;
    localparam t_ent ENT_BRACKET = 3'd3;
    localparam t_ent ENT_SQ      = 3'd4;
    localparam t_ent ENT_DQ      = 3'd5;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic               error_seen;
        logic               verdict_valid;
        logic               text_ok;
        logic [DEPTH_W-1:0] nesting_depth;
    } t_out_word;

    function automatic t_sig bqcc_classify(input logic [7:0] b);
        t_sig s;
        case (b)
            8'h28:   s = SIG_LPAR;
            8'h29:   s = SIG_RPAR;
            8'h7B:   s = SIG_LBRC;
            8'h7D:   s = SIG_RBRC;
            8'h5B:   s = SIG_LBRK;
            8'h5D:   s = SIG_RBRK;
            8'h27:   s = SIG_SQ;
            8'h22:   s = SIG_DQ;
            8'h5C:   s = SIG_BSL;
            8'h2F:   s = SIG_SLASH;
            8'h2A:   s = SIG_STAR;
            default: s = SIG_NONE;
        endcase
        return s;
    endfunction

    function automatic t_ent bqcc_entry(input t_sig s);
        t_ent e;
        case (s)
            SIG_LPAR, SIG_RPAR: e = ENT_PAREN;
            SIG_LBRC, SIG_RBRC: e = ENT_BRACE;
            SIG_LBRK, SIG_RBRK: e = ENT_BRACKET;
            SIG_SQ:             e = ENT_SQ;
            SIG_DQ:             e = ENT_DQ;
            default:            e = ENT_NONE;
        endcase
        return e;
    endfunction

endpackage

@@ rtl/core/bracket_quote_comment_checker.sv @@
// Bracket, quote and comment checker. One source byte in per word, one status word out.
// Input channel: i_in_valid / o_in_stall with i_in_word; output: o_out_valid / i_out_stall
// with o_out_word. Depends on bqcc_pkg and the checker macro header.
// Each accepted byte gives exactly one status word, held in the result register
// when that is free, else in the skid register. A byte is accepted in every cycle
// while o_in_stall is low: the top of the open stack sits in a register and the
// entry below it is read ahead from the stack memory each cycle, so a push or a pop
// needs one compare and one memory access. A two-entry output buffer (result register
// plus skid register) lets the block take a byte while a result waits; o_in_stall rises
// only when both entries are full, and stays high until the receiver drops
// i_out_stall. The word for the byte flagged last_byte carries the verdict,
// after which the stack, comment and error state are cleared for the next
// text. Reset empties the output buffer and clears that state; the stack
// memory needs no clearing since only entries below the count are read.
`include "bracket_quote_comment_checker_macros.svh"

module bracket_quote_comment_checker #(
    parameter int STACK_DEPTH = bqcc_pkg::BQCC_STACK_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bqcc_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bqcc_pkg::t_out_word o_out_word
);
    import bqcc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    logic [CW-1:0] r_count;
    logic          r_in_comment;
    t_sig          r_prev;
    logic          r_err;
    t_ent          r_top;
    t_ent          r_below;
    t_ent          mem [STACK_DEPTH];

    logic          r_out_valid;
    logic          r_skid_valid;
    t_out_word     r_out_word;
    t_out_word     r_skid_word;

    logic          in_acc;
    logic          out_take;

    t_sig          sig;
    t_ent          ent;
    logic          stack_empty;
    logic          stack_full;
    logic          top_hit;
    logic          want_push;
    logic          do_push;
    logic          do_pop;
    logic [CW-1:0] n_count;
    logic          n_in_comment;
    t_sig          n_prev;
    logic          n_err;
    t_ent          n_top;
    t_out_word     res;
    logic [CW+DEPTH_W-1:0] depth_ext;

    logic [CW-1:0] eff_count;
    logic [CW-1:0] rd_diff;
    logic [CW-1:0] wr_diff;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;

    assign in_acc     = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign sig         = bqcc_classify(i_in_word.text_byte);
    assign ent         = bqcc_entry(sig);
    assign stack_empty = (r_count == '0);
    assign stack_full  = (r_count >= CW'(STACK_DEPTH));
    assign top_hit     = !stack_empty && (r_top == ent);

    always_comb begin
        n_count      = r_count;
        n_in_comment = r_in_comment;
        n_prev       = r_prev;
        n_err        = r_err;
        n_top        = r_top;
        want_push    = 1'b0;
        do_push      = 1'b0;
        do_pop       = 1'b0;
        if (sig != SIG_NONE) begin
            n_prev = sig;
            if (sig == SIG_SLASH && r_prev == SIG_STAR) begin
                n_in_comment = 1'b0;
            end
            if (sig == SIG_STAR && r_prev == SIG_SLASH) begin
                n_in_comment = 1'b1;
            end
            if (!n_in_comment && !r_err) begin
                case (sig)
                    SIG_LPAR, SIG_LBRC, SIG_LBRK: begin
                        want_push = 1'b1;
                    end
                    SIG_RPAR, SIG_RBRC, SIG_RBRK: begin
                        if (top_hit) begin
                            do_pop = 1'b1;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    SIG_SQ, SIG_DQ: begin
                        if (r_prev != SIG_BSL) begin
                            if (top_hit) begin
                                do_pop = 1'b1;
                            end else begin
                                want_push = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (want_push) begin
            if (stack_full) begin
                n_err = 1'b1;
            end else begin
                do_push = 1'b1;
            end
        end
        if (do_push) begin
            n_count = r_count + CW'(1);
            n_top   = ent;
        end else if (do_pop) begin
            n_count = r_count - CW'(1);
            n_top   = r_below;
        end

        depth_ext         = {{DEPTH_W{1'b0}}, n_count};
        res.error_seen    = n_err;
        res.verdict_valid = i_in_word.last_byte;
        res.text_ok       = i_in_word.last_byte && !n_err && !n_in_comment
                            && (n_count == '0);
        res.nesting_depth = depth_ext[DEPTH_W-1:0];

        // clear for the next text
        if (i_in_word.last_byte) begin
            n_count      = '0;
            n_in_comment = 1'b0;
            n_prev       = SIG_NONE;
            n_err        = 1'b0;
        end
    end

    assign eff_count = in_acc ? n_count : r_count;
    assign rd_diff   = eff_count - CW'(2);
    assign wr_diff   = r_count - CW'(1);
    assign rd_addr   = rd_diff[IW-1:0];
    assign wr_addr   = wr_diff[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_in_comment <= 1'b0;
            r_prev       <= SIG_NONE;
            r_err        <= 1'b0;
        end else if (in_acc) begin
            r_count      <= n_count;
            r_in_comment <= n_in_comment;
            r_prev       <= n_prev;
            r_err        <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_top <= n_top;
        end
    end

    // spill the old top below the new one; prefetch the entry under the top
    always_ff @(posedge i_clk) begin
        if (in_acc && do_push && !stack_empty) begin
            mem[wr_addr] <= r_top;
        end
        if (in_acc && do_push) begin
            r_below <= r_top;
        end else begin
            r_below <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_word <= r_skid_word;
            end
        end else if (in_acc) begin
            if (r_out_valid && !out_take) begin
                r_skid_word <= res;
            end else begin
                r_out_word <= res;
            end
        end
    end

    `BQCC_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid register holds a word while the result register is empty")
    `BQCC_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1,
        r_count <= CW'(STACK_DEPTH), "stack count beyond depth")
    `BQCC_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, in_acc && i_in_word.last_byte,
        r_count == '0 && !r_in_comment && !r_err && r_prev == SIG_NONE,
        "state not cleared after the last byte")
    `BQCC_ASSERT_NEXT(a_error_holds, i_clk, i_rst_n, r_err && !(in_acc && i_in_word.last_byte),
        r_err, "error dropped before the text ended")
    `BQCC_ASSERT_NOW(a_ok_is_verdict, i_clk, i_rst_n, r_out_valid && r_out_word.text_ok,
        r_out_word.verdict_valid && !r_out_word.error_seen
        && r_out_word.nesting_depth == '0, "text_ok on a word that is no clean verdict")

endmodule

@@ dv/bqcc_status_checker.sv @@
// Status checker for the bracket, quote and comment checker: watches both word channels,
// predicts each status word from the accepted bytes and compares it field by field.
// Depends on bqcc_pkg for the word types and the significant-byte and stack-entry codes.
module bqcc_status_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  bqcc_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  bqcc_pkg::t_out_word i_out_word,
    output int                  o_mismatches,
    output int                  o_pending,
    output int                  o_checked
);
    import bqcc_pkg::*;

    t_ent      open_entries [BQCC_STACK_DEPTH];
    int        open_count;
    logic      comment_open;
    t_sig      last_sig;
    logic      error_held;
    t_out_word expected_status [$];

    function automatic void clear_text();
        open_count   = 0;
        comment_open = 1'b0;
        last_sig     = SIG_NONE;
        error_held   = 1'b0;
    endfunction

    function automatic void push_open(input t_ent e);
        if (open_count >= BQCC_STACK_DEPTH) begin
            error_held = 1'b1;
        end else begin
            open_entries[open_count] = e;
            open_count++;
        end
    endfunction

    function automatic t_ent top_open();
        return (open_count == 0) ? ENT_NONE : open_entries[open_count-1];
    endfunction

    function automatic t_out_word predict_status(input t_in_word w);
        t_sig      sig;
        t_ent      want;
        t_out_word res;
        case (w.text_byte)
            "(":     sig = SIG_LPAR;
            ")":     sig = SIG_RPAR;
            "{":     sig = SIG_LBRC;
            "}":     sig = SIG_RBRC;
            "[":     sig = SIG_LBRK;
            "]":     sig = SIG_RBRK;
            "'":     sig = SIG_SQ;
            "\"":    sig = SIG_DQ;
            "\\":    sig = SIG_BSL;
            "/":     sig = SIG_SLASH;
            "*":     sig = SIG_STAR;
            default: sig = SIG_NONE;
        endcase
        if (sig != SIG_NONE) begin
            if (sig == SIG_SLASH && last_sig == SIG_STAR) comment_open = 1'b0;
            if (sig == SIG_STAR && last_sig == SIG_SLASH) comment_open = 1'b1;
            if (!comment_open && !error_held) begin
                case (sig)
                    SIG_LPAR: push_open(ENT_PAREN);
                    SIG_LBRC: push_open(ENT_BRACE);
                    SIG_LBRK: push_open(ENT_BRACKET);
                    SIG_RPAR, SIG_RBRC, SIG_RBRK: begin
                        want = (sig == SIG_RPAR) ? ENT_PAREN :
                               (sig == SIG_RBRC) ? ENT_BRACE : ENT_BRACKET;
                        if (open_count == 0 || top_open() != want) error_held = 1'b1;
                        else open_count--;
                    end
                    SIG_SQ, SIG_DQ: begin
                        want = (sig == SIG_SQ) ? ENT_SQ : ENT_DQ;
                        if (last_sig != SIG_BSL) begin
                            if (open_count > 0 && top_open() == want) open_count--;
                            else push_open(want);
                        end
                    end
                    default: ;
                endcase
            end
            last_sig = sig;
        end
        res.error_seen    = error_held;
        res.verdict_valid = w.last_byte;
        res.text_ok       = w.last_byte && !error_held && !comment_open && open_count == 0;
        res.nesting_depth = open_count[DEPTH_W-1:0];
        if (w.last_byte) clear_text();
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            clear_text();
            expected_status.delete();
            o_mismatches = 0;
            o_pending    = 0;
            o_checked    = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_status.size() == 0) begin
                    $error("status word %h arrived with nothing expected", i_out_word);
                    o_mismatches++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("error_seen", 8'(want.error_seen), 8'(i_out_word.error_seen));
                    check_field("verdict_valid", 8'(want.verdict_valid),
                                8'(i_out_word.verdict_valid));
                    check_field("text_ok", 8'(want.text_ok), 8'(i_out_word.text_ok));
                    check_field("nesting_depth", 8'(want.nesting_depth),
                                8'(i_out_word.nesting_depth));
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) expected_status.push_back(predict_status(i_in_word));
            o_pending = expected_status.size();
        end
    end

endmodule

@@ dv/tb_bracket_quote_comment_checker.sv @@
// Testbench top for the bracket, quote and comment checker: clock, reset, byte stimulus
// with idling and a long receiver hold-off, and the final verdict.
// Depends on bqcc_pkg, the block and bqcc_status_checker.
module tb_bracket_quote_comment_checker;
    import bqcc_pkg::*;

    localparam int HOLD_CYCLES          = 150;
    localparam int DRAIN_CYCLES         = 20;
    localparam int RANDOM_BYTES_PER_MIX = 350;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_stall = 1'b0;
    t_in_word  in_word   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_req      = 1'b0;
    int   mismatches;
    int   pending;
    int   checked;
    int   texts_sent    = 0;
    int   bytes_sent    = 0;
    int   deep_texts    = 0;

    logic [7:0] text_buf [$];

    always #10 i_clk = ~i_clk;

    bracket_quote_comment_checker i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    bqcc_status_checker u_status_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    task automatic put_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{text_byte: b, last_byte: last};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++) put_byte(text_buf[i], i == text_buf.size() - 1);
        texts_sent++;
    endtask

    task automatic send_string(input string s);
        text_buf.delete();
        foreach (s[i]) text_buf.push_back(s[i]);
        send_text();
    endtask

    function automatic bit is_special(input logic [7:0] b);
        string sp = "(){}[]'\"\\/*";
        foreach (sp[i]) if (sp[i] == b) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void add_wellformed(input int target);
        string      opens  = "({['\"";
        string      closes = ")}]'\"";
        string      junk   = "(){}[]'\"\\ q";
        logic [7:0] closers [$];
        logic [7:0] b;
        int         k;
        int         start;
        start = text_buf.size();
        while (text_buf.size() - start < target) begin
            k = $urandom_range(99);
            if (k < 30 && closers.size() < 20) begin
                k = $urandom_range(4);
                if (k >= 3 && closers.size() > 0 && closers[$] == opens[k]) k = 7 - k;
                text_buf.push_back(opens[k]);
                closers.push_back(closes[k]);
            end else if (k < 55 && closers.size() > 0) begin
                text_buf.push_back(closers.pop_back());
            end else if (k < 80) begin
                do b = 8'($urandom_range(255)); while (is_special(b));
                text_buf.push_back(b);
            end else if (k < 90) begin
                text_buf.push_back("/");
                text_buf.push_back("*");
                repeat ($urandom_range(5)) text_buf.push_back(junk[$urandom_range(junk.len() - 1)]);
                text_buf.push_back("*");
                text_buf.push_back("/");
            end else begin
                text_buf.push_back("\\");
                text_buf.push_back($urandom_range(1) ? "'" : "\"");
            end
        end
        while (closers.size() > 0) text_buf.push_back(closers.pop_back());
    endfunction

    function automatic void build_text();
        string      sp     = "(){}[]'\"\\/*";
        string      opens  = "({[";
        string      closes = ")}]";
        logic [7:0] closers [$];
        int         r;
        int         n;
        text_buf.delete();
        r = $urandom_range(99);
        if (r < 60) begin
            add_wellformed($urandom_range(4, 40));
            if ($urandom_range(4) == 0)
                text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
        end else if (r < 78) begin
            repeat ($urandom_range(1, 30))
                text_buf.push_back($urandom_range(1) ? sp[$urandom_range(10)]
                                                     : 8'($urandom_range(255)));
        end else if (r < 95) begin
            add_wellformed($urandom_range(4, 30));
            case ($urandom_range(2))
                0: if (text_buf.size() > 1) void'(text_buf.pop_back());
                1: text_buf.push_back(closes[$urandom_range(2)]);
                default: begin
                    text_buf.push_back("/");
                    text_buf.push_back("*");
                end
            endcase
        end else begin
            n = ($urandom_range(2) == 0) ? BQCC_STACK_DEPTH : $urandom_range(60, 68);
            if (n > BQCC_STACK_DEPTH) deep_texts++;
            repeat (n) begin
                r = $urandom_range(2);
                text_buf.push_back(opens[r]);
                closers.push_back(closes[r]);
            end
            while (closers.size() > 0) text_buf.push_back(closers.pop_back());
        end
    endfunction

    task automatic run_mix(input int send_pct, input int recv_pct);
        int start;
        start         = bytes_sent;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (bytes_sent - start < RANDOM_BYTES_PER_MIX) begin
            build_text();
            send_text();
        end
    endtask

    initial begin : receiver
        int held;
        held = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && held < HOLD_CYCLES) begin
                out_stall <= 1'b1;
                held++;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 32;
        recv_idle_pct = 76;
        send_string("*/[]");
        send_string("/*/{}");
        send_string(")(");
        send_string("([)]");
        send_string("'\"\\\"\"'");
        send_string("/*(");
        text_buf = '{8'h00, 8'hFF};
        send_text();

        run_mix(32, 76);
        run_mix(76, 32);
        hold_req <= 1'b1;
        run_mix(0, 0);
        in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d texts, %0d bytes (%0d past the stack limit) under three idle mixes",
                 texts_sent, bytes_sent, deep_texts);
        $display("and a %0d-cycle output hold-off; %0d status words compared.",
                 HOLD_CYCLES, checked);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_bracket_quote_comment_checker OK");
        end else begin
            $display("tb_bracket_quote_comment_checker NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("tb_bracket_quote_comment_checker NOT OK");
        $finish;
    end

endmodule

@@ bracket_quote_comment_checker.f @@
+incdir+rtl/core
rtl/core/bqcc_pkg.sv
rtl/core/bracket_quote_comment_checker.sv
dv/bqcc_status_checker.sv
dv/tb_bracket_quote_comment_checker.sv
